>>> rtl/local_time_step_from_face_radii_defines.svh
// Assertion macros used by the local time step top level.
`ifndef LOCAL_TIME_STEP_FROM_FACE_RADII_DEFINES_SVH
`define LOCAL_TIME_STEP_FROM_FACE_RADII_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LTS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define LTS_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTS_ASSERT(lbl, clk, rstn, prop, msg)
`define LTS_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/lts_pkg.sv
// Shared types and constants for the local time step block.
package lts_pkg;
  localparam int FracBits   = 16;
  localparam int WeightFrac = 8;
  localparam int SumW       = 48;
  localparam int NumW       = 49;
  localparam int QExtra     = FracBits - WeightFrac;
  localparam int QBits      = NumW + QExtra;
  localparam int QCntW      = $clog2(QBits + 1);

  localparam logic [0:0] RegViscousWeight = 1'b0;
  localparam logic [0:0] RegCflNumber     = 1'b1;

  // cell job handed from the accumulating front to the divider
  typedef struct packed {
    logic [SumW-1:0] sum;
    logic [NumW-1:0] num;
  } cell_job_t;

  typedef enum logic [1:0] {
    DivIdle,
    DivRun,
    DivDone
  } div_state_e;
endpackage

>>> rtl/local_time_step_from_face_radii.sv
// Local time step from face spectral radii: faces stream in at one per cycle and
// are summed with saturation in the front end; on the last face of a cell the sum
// and 2*CFL*volume go through a one-deep queue to a restoring divider that takes
// the job in its idle state, divides at one quotient bit per cycle in its run state
// and holds the result in its done state until it is taken, so it takes no new cell
// before the last result has been taken; a zero sum skips the run state. Face input
// stalls only while a finished cell waits for the divider to free up.
`include "local_time_step_from_face_radii_defines.svh"
module local_time_step_from_face_radii (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] inviscid_radius_a_i,
  input  logic [31:0] inviscid_radius_b_i,
  input  logic [31:0] viscous_radius_a_i,
  input  logic [31:0] viscous_radius_b_i,
  input  logic        right_differs_i,
  input  logic        left_differs_i,
  input  logic [31:0] cell_volume_i,
  input  logic        last_face_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] time_step_o,
  output logic        zero_sum_o
);
  logic [15:0]        weight_q, cfl_q;
  logic               job_valid, job_ready;
  lts_pkg::cell_job_t job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= 16'd1024;
      cfl_q    <= 16'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lts_pkg::RegViscousWeight: weight_q <= cfg_data_i;
        lts_pkg::RegCflNumber:     cfl_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lts_front u_front (
    .clk_i, .rst_ni,
    .viscous_weight_i (weight_q),
    .cfl_number_i     (cfl_q),
    .in_valid_i, .in_ready_o,
    .inviscid_radius_a_i, .inviscid_radius_b_i,
    .viscous_radius_a_i, .viscous_radius_b_i,
    .right_differs_i, .left_differs_i, .cell_volume_i, .last_face_i,
    .job_valid_o (job_valid),
    .job_ready_i (job_ready),
    .job_o       (job)
  );

  lts_divider u_div (
    .clk_i, .rst_ni,
    .job_valid_i (job_valid),
    .job_ready_o (job_ready),
    .job_i       (job),
    .out_valid_o, .out_ready_i, .time_step_o, .zero_sum_o
  );

  `LTS_ASSERT(a_zero_max, clk_i, rst_ni, out_valid_o && zero_sum_o |-> time_step_o == '1, "zero sum must give max step")
  `LTS_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(time_step_o), "result dropped")
  `LTS_ASSERT(a_job_hold, clk_i, rst_ni, job_valid && !job_ready |=> job_valid, "queued cell lost")
endmodule

>>> rtl/lts_front.sv
// Front end: per-face accumulation of weighted spectral radii.
module lts_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [15:0]                viscous_weight_i,
  input  logic [15:0]                cfl_number_i,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [31:0]                inviscid_radius_a_i,
  input  logic [31:0]                inviscid_radius_b_i,
  input  logic [31:0]                viscous_radius_a_i,
  input  logic [31:0]                viscous_radius_b_i,
  input  logic                       right_differs_i,
  input  logic                       left_differs_i,
  input  logic [31:0]                cell_volume_i,
  input  logic                       last_face_i,
  output logic                       job_valid_o,
  input  logic                       job_ready_i,
  output lts_pkg::cell_job_t         job_o
);
  // two-stage face pipe: stage 1 registers the weighted side terms
  logic                          s1_valid_q, s1_valid_d;
  logic [40:0]                   s1_term_a_q, s1_term_b_q;
  logic                          s1_last_q;
  logic [lts_pkg::NumW-1:0]      s1_num_q;
  logic [lts_pkg::SumW-1:0]      sum_q, sum_d;
  logic                          job_valid_q, job_valid_d;
  lts_pkg::cell_job_t            job_q, job_d;
  logic [47:0]                   prod_a, prod_b;
  logic [49:0]                   add1, add2;
  logic [lts_pkg::SumW-1:0]      sat1;
  logic [lts_pkg::NumW-1:0]      num_c;
  logic                          s1_go;

  // stage 1 stalls only when a finished cell cannot be queued
  assign s1_go      = !(s1_valid_q && s1_last_q && job_valid_q && !job_ready_i);
  assign in_ready_o = s1_go;
  assign s1_valid_d = s1_go ? in_valid_i : s1_valid_q;

  assign prod_a = 48'(viscous_radius_a_i) * 48'(viscous_weight_i);
  assign prod_b = 48'(viscous_radius_b_i) * 48'(viscous_weight_i);
  assign num_c  = lts_pkg::NumW'({cfl_number_i, 1'b0}) * lts_pkg::NumW'(cell_volume_i);

  // side term needs 41 bits: a 32-bit radius plus a 40-bit weighted radius
  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s1_term_a_q <= right_differs_i ?
                     41'(inviscid_radius_a_i) + 41'(prod_a[47:lts_pkg::WeightFrac]) : '0;
      s1_term_b_q <= left_differs_i ?
                     41'(inviscid_radius_b_i) + 41'(prod_b[47:lts_pkg::WeightFrac]) : '0;
      s1_last_q   <= last_face_i;
      s1_num_q    <= num_c;
    end
  end

  // saturating accumulation of both sides
  always_comb begin
    add1  = 50'(sum_q) + 50'(s1_term_a_q);
    sat1  = (add1 > 50'({lts_pkg::SumW{1'b1}})) ? '1 : add1[lts_pkg::SumW-1:0];
    add2  = 50'(sat1) + 50'(s1_term_b_q);
    sum_d = sum_q;
    job_valid_d = job_valid_q && !job_ready_i;
    job_d = job_q;
    if (s1_valid_q && s1_go) begin
      sum_d = (add2 > 50'({lts_pkg::SumW{1'b1}})) ? '1 : add2[lts_pkg::SumW-1:0];
      if (s1_last_q) begin
        job_d.sum   = sum_d;
        job_d.num   = s1_num_q;
        job_valid_d = 1'b1;
        sum_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      sum_q       <= '0;
      job_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      sum_q       <= sum_d;
      job_valid_q <= job_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q <= job_d;
  end

  assign job_valid_o = job_valid_q;
  assign job_o       = job_q;
endmodule

>>> rtl/lts_divider.sv
// Back end: restoring divider with saturation, plus output register.
module lts_divider (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  output logic               job_ready_o,
  input  lts_pkg::cell_job_t job_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        time_step_o,
  output logic               zero_sum_o
);
  lts_pkg::div_state_e            state_q, state_d;
  logic [lts_pkg::QBits-1:0]      dividend_q, dividend_d;
  logic [lts_pkg::SumW:0]         rem_q, rem_d;
  logic [lts_pkg::SumW-1:0]       div_q, div_d;
  logic [lts_pkg::QCntW-1:0]      cnt_q, cnt_d;
  logic [lts_pkg::QBits-1:0]      quo_q, quo_d;
  logic [31:0]                    step_q, step_d;
  logic                           zero_q, zero_d;
  logic [lts_pkg::SumW+1:0]       trial;

  // one quotient bit per cycle, MSB first over the scaled numerator
  always_comb begin
    state_d    = state_q;
    dividend_d = dividend_q;
    rem_d      = rem_q;
    div_d      = div_q;
    cnt_d      = cnt_q;
    quo_d      = quo_q;
    step_d     = step_q;
    zero_d     = zero_q;
    job_ready_o = 1'b0;
    trial = {rem_q, dividend_q[lts_pkg::QBits-1]} - (lts_pkg::SumW+2)'(div_q);
    unique case (state_q)
      lts_pkg::DivIdle: begin
        job_ready_o = 1'b1;
        if (job_valid_i) begin
          if (job_i.sum == '0) begin
            step_d  = '1;
            zero_d  = 1'b1;
            state_d = lts_pkg::DivDone;
          end else begin
            dividend_d = {job_i.num, {lts_pkg::QExtra{1'b0}}};
            rem_d      = '0;
            div_d      = job_i.sum;
            quo_d      = '0;
            cnt_d      = lts_pkg::QCntW'(lts_pkg::QBits);
            zero_d     = 1'b0;
            state_d    = lts_pkg::DivRun;
          end
        end
      end
      lts_pkg::DivRun: begin
        dividend_d = dividend_q << 1;
        if (!trial[lts_pkg::SumW+1]) begin
          rem_d = trial[lts_pkg::SumW:0];
          quo_d = {quo_q[lts_pkg::QBits-2:0], 1'b1};
        end else begin
          rem_d = {rem_q[lts_pkg::SumW-1:0], dividend_q[lts_pkg::QBits-1]};
          quo_d = {quo_q[lts_pkg::QBits-2:0], 1'b0};
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == lts_pkg::QCntW'(1)) begin
          step_d  = (quo_d[lts_pkg::QBits-1:32] != '0) ? '1 : quo_d[31:0];
          state_d = lts_pkg::DivDone;
        end
      end
      lts_pkg::DivDone: begin
        if (out_ready_i) state_d = lts_pkg::DivIdle;
      end
      default: state_d = lts_pkg::DivIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lts_pkg::DivIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dividend_q <= dividend_d;
    rem_q      <= rem_d;
    div_q      <= div_d;
    quo_q      <= quo_d;
    step_q     <= step_d;
    zero_q     <= zero_d;
  end

  assign out_valid_o = (state_q == lts_pkg::DivDone);
  assign time_step_o = step_q;
  assign zero_sum_o  = zero_q;
endmodule
